FILE: sv/sparse_column_abs_sum_assert.svh
// assertion macros for the checker of sparse_column_abs_sum
`ifndef SPARSE_COLUMN_ABS_SUM_ASSERT_SVH
`define SPARSE_COLUMN_ABS_SUM_ASSERT_SVH

// expression holds in the same cycle as the condition
`define SCAS_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// expression holds in the next cycle after the condition
`define SCAS_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

// expression holds after a delay once the condition holds
`define SCAS_ASSERT_AFTER2(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> ##2 (expr)) \
        else $error(msg);

`endif

FILE: sv/scas_pkg.sv
package scas_pkg;

    // column store geometry
    localparam int MAX_COLUMNS = 1024;
    localparam int ADDR_W      = $clog2(MAX_COLUMNS);
    localparam int COL_W       = 10;

    // data widths
    localparam int PART_W = 16;
    localparam int SQ_W   = 2 * PART_W;
    localparam int ROOT_W = SQ_W / 2;
    localparam int SUM_W  = 40;

    localparam logic [SUM_W-1:0]  SUM_MAX = {SUM_W{1'b1}};
    localparam logic [ROOT_W-1:0] ONE_Q14 = ROOT_W'(16384);

    // root unit iteration count
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(SQRT_STEPS);

    // operation codes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // request to the root unit
    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] radicand;
    } sqrt_req_t;

    // answer from the root unit
    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

endpackage

FILE: sv/scas_ram.sv
module scas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds its data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/scas_sqrt.sv
module scas_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  scas_pkg::sqrt_req_t req,
    output scas_pkg::sqrt_rsp_t rsp
);

    localparam int REM_W = scas_pkg::ROOT_W + 2;
    localparam int SH_W  = REM_W + 2;

    logic                          running_reg, running_next;
    logic                          done_reg, done_next;
    logic [scas_pkg::STEP_W-1:0]   cnt_reg, cnt_next;
    logic [scas_pkg::SQ_W-1:0]     x_reg, x_next;
    logic [REM_W-1:0]              rem_reg, rem_next;
    logic [scas_pkg::ROOT_W-1:0]   root_reg, root_next;
    logic [SH_W-1:0]               rem_sh;
    logic [SH_W-1:0]               trial;

    // one root bit per cycle, restoring digit recurrence
    assign rem_sh = {rem_reg, x_reg[scas_pkg::SQ_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};

    always_comb
    begin
        running_next = running_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        x_next       = x_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        if (req.start)
        begin
            running_next = 1'b1;
            cnt_next     = '0;
            x_next       = req.radicand;
            rem_next     = '0;
            root_next    = '0;
        end
        else if (running_reg)
        begin
            x_next = {x_reg[scas_pkg::SQ_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_reg[scas_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(rem_sh);
                root_next = {root_reg[scas_pkg::ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == scas_pkg::STEP_W'(scas_pkg::SQRT_STEPS - 1))
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

FILE: sv/sparse_column_abs_sum.sv
// channel   | signals                                         | direction
// ----------+-------------------------------------------------+----------
// command   | start, operation, column, real_part, imag_part  | in
//           | busy                                            | out
// result    | done, column_sum, saturated                     | out
// config    | cfg_we, cfg_data (unit_weight)                  | in
//
// after reset the column store is cleared one entry a cycle, all 1024 entries, while busy
// a read transaction passes through ST_READ, busy there, and raises done from a register
// an in-range add with unit_weight set is busy only in ST_UPDATE after acceptance
// an in-range add of a magnitude is busy through squares, 16-step root and update
// the root unit iterates one result bit per cycle
// done lasts one cycle; the receiver cannot stall
module sparse_column_abs_sum (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           operation,
    input  logic [scas_pkg::COL_W-1:0]     column,
    input  logic signed [scas_pkg::PART_W-1:0] real_part,
    input  logic signed [scas_pkg::PART_W-1:0] imag_part,
    output logic                           done,
    output logic [scas_pkg::SUM_W-1:0]     column_sum,
    output logic                           saturated,
    input  logic                           cfg_we,
    input  logic                           cfg_data
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_READ   = 6'b000100,
        ST_SQUARE = 6'b001000,
        ST_ROOT   = 6'b010000,
        ST_UPDATE = 6'b100000
    } state_t;

    state_t                             state_reg, state_next;
    logic [scas_pkg::ADDR_W-1:0]        clr_cnt_reg, clr_cnt_next;
    logic                               unit_weight_reg, unit_weight_next;
    logic                               done_reg, done_next;
    logic [scas_pkg::SUM_W-1:0]         column_sum_reg, column_sum_next;
    logic                               saturated_reg, saturated_next;
    logic [scas_pkg::ADDR_W-1:0]        addr_reg, addr_next;
    logic                               in_range_reg, in_range_next;
    logic [scas_pkg::ROOT_W-1:0]        add_val_reg, add_val_next;
    logic signed [scas_pkg::SQ_W-1:0]   sq_re_reg, sq_re_next;
    logic signed [scas_pkg::SQ_W-1:0]   sq_im_reg, sq_im_next;

    logic                               in_range;
    logic [scas_pkg::SUM_W:0]           sum_wide;
    logic [scas_pkg::SUM_W-1:0]         sum_sat;

    logic                               ram_we;
    logic [scas_pkg::ADDR_W-1:0]        ram_waddr;
    logic [scas_pkg::SUM_W-1:0]         ram_wdata;
    logic                               ram_re;
    logic [scas_pkg::SUM_W-1:0]         ram_rdata;

    scas_pkg::sqrt_req_t                sqrt_req;
    scas_pkg::sqrt_rsp_t                sqrt_rsp;

    // column sum store
    scas_ram #(
        .WIDTH (scas_pkg::SUM_W),
        .DEPTH (scas_pkg::MAX_COLUMNS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (scas_pkg::ADDR_W'(column)),
        .rdata (ram_rdata)
    );

    // magnitude root unit
    scas_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    assign in_range = 32'(column) < 32'(scas_pkg::MAX_COLUMNS);

    // saturating accumulate of the stored sum
    assign sum_wide = {1'b0, ram_rdata} + (scas_pkg::SUM_W + 1)'(add_val_reg);
    assign sum_sat  = sum_wide[scas_pkg::SUM_W] ? scas_pkg::SUM_MAX
                                                : sum_wide[scas_pkg::SUM_W-1:0];

    // store access
    assign ram_re    = (state_reg == ST_IDLE) && start;
    assign ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_UPDATE);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : addr_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : sum_sat;

    // root request from the registered squares
    assign sqrt_req.start    = (state_reg == ST_SQUARE);
    assign sqrt_req.radicand = scas_pkg::SQ_W'($unsigned(sq_re_reg))
                             + scas_pkg::SQ_W'($unsigned(sq_im_reg));

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        unit_weight_next = cfg_we ? cfg_data : unit_weight_reg;
        done_next        = 1'b0;
        column_sum_next  = column_sum_reg;
        saturated_next   = saturated_reg;
        addr_next        = addr_reg;
        in_range_next    = in_range_reg;
        add_val_next     = add_val_reg;
        sq_re_next       = sq_re_reg;
        sq_im_next       = sq_im_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == scas_pkg::ADDR_W'(scas_pkg::MAX_COLUMNS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    addr_next     = scas_pkg::ADDR_W'(column);
                    in_range_next = in_range;
                    sq_re_next    = scas_pkg::SQ_W'(real_part) * scas_pkg::SQ_W'(real_part);
                    sq_im_next    = scas_pkg::SQ_W'(imag_part) * scas_pkg::SQ_W'(imag_part);
                    if (operation == scas_pkg::OP_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else if (!in_range)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (unit_weight_reg)
                    begin
                        add_val_next = scas_pkg::ONE_Q14;
                        state_next   = ST_UPDATE;
                    end
                    else
                    begin
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_READ:
            begin
                done_next       = 1'b1;
                column_sum_next = in_range_reg ? ram_rdata : '0;
                saturated_next  = in_range_reg && (ram_rdata == scas_pkg::SUM_MAX);
                state_next      = ST_IDLE;
            end
            ST_SQUARE:
            begin
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (sqrt_rsp.done)
                begin
                    add_val_next = sqrt_rsp.root;
                    state_next   = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            unit_weight_reg <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            unit_weight_reg <= unit_weight_next;
            done_reg        <= done_next;
        end
    end

    // transaction payload
    always_ff @(posedge clk)
    begin
        column_sum_reg <= column_sum_next;
        saturated_reg  <= saturated_next;
        addr_reg       <= addr_next;
        in_range_reg   <= in_range_next;
        add_val_reg    <= add_val_next;
        sq_re_reg      <= sq_re_next;
        sq_im_reg      <= sq_im_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign column_sum = column_sum_reg;
    assign saturated  = saturated_reg;

endmodule

FILE: sv/scas_checker.sv
`include "sparse_column_abs_sum_assert.svh"

module scas_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       operation,
    input logic                       done,
    input logic [scas_pkg::SUM_W-1:0] column_sum,
    input logic                       saturated
);

    // every accepted read transaction is answered with a done strobe
    `SCAS_ASSERT_AFTER2(a_read_answered, start && !busy && operation == scas_pkg::OP_READ, done, "read without result")

    // a read holds the block busy in the following cycle
    `SCAS_ASSERT_NEXT(a_read_busy, start && !busy && operation == scas_pkg::OP_READ, busy, "read not held busy")

    // results never come back to back
    `SCAS_ASSERT_NEXT(a_done_single, done, !done, "result strobe repeated")

    // the saturation flag goes with a full sum
    `SCAS_ASSERT_NOW(a_sat_full, done && saturated, column_sum == scas_pkg::SUM_MAX, "saturated without full sum")

endmodule

bind sparse_column_abs_sum scas_checker u_scas_checker (.*);

FILE: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scas_pkg::*;

    // one column read as the block should report it
    typedef struct {
        logic [SUM_W-1:0] sum;
        logic             sat;
    } column_read_t;

    // one row of the directed table
    typedef struct {
        logic                     weight;
        logic                     op;
        logic [COL_W-1:0]         col;
        logic signed [PART_W-1:0] re;
        logic signed [PART_W-1:0] im;
        bit                       typed;
        logic [SUM_W-1:0]         typed_sum;
    } directed_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     operation;
    logic [COL_W-1:0]         column;
    logic signed [PART_W-1:0] real_part;
    logic signed [PART_W-1:0] imag_part;
    logic                     done;
    logic [SUM_W-1:0]         column_sum;
    logic                     saturated;
    logic                     cfg_we;
    logic                     cfg_data;

    // shadow copy of the column store and weight register
    logic [SUM_W-1:0] column_totals [MAX_COLUMNS];
    logic             unit_weight_q;
    column_read_t     pending_reads [$];
    int               error_count;
    int               idle_pct;

    sparse_column_abs_sum uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .column     (column),
        .real_part  (real_part),
        .imag_part  (imag_part),
        .done       (done),
        .column_sum (column_sum),
        .saturated  (saturated),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %0s", $time, msg);
        error_count++;
    endtask

    // floor square root of re^2 + im^2, one result bit per trial
    function automatic logic [ROOT_W-1:0] magnitude_root(
        input logic signed [PART_W-1:0] re,
        input logic signed [PART_W-1:0] im
    );
        longint unsigned   power;
        logic [ROOT_W-1:0] root;
        logic [ROOT_W-1:0] trial;
        power = longint'(re) * longint'(re) + longint'(im) * longint'(im);
        root  = '0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            trial = root | (ROOT_W'(1) << b);
            if (longint'(trial) * longint'(trial) <= power)
                root = trial;
        end
        return root;
    endfunction

    // update the shadow store for an accepted transaction, queue any read
    function automatic void account_transaction(
        input logic                     op,
        input logic [COL_W-1:0]         col,
        input logic signed [PART_W-1:0] re,
        input logic signed [PART_W-1:0] im,
        input bit                       use_typed,
        input logic [SUM_W-1:0]         typed_sum
    );
        logic [SUM_W-1:0] addend;
        column_read_t     result;
        if (op == OP_ADD)
        begin
            if (int'(col) < MAX_COLUMNS)
            begin
                addend = unit_weight_q ? SUM_W'(ONE_Q14) : SUM_W'(magnitude_root(re, im));
                if (column_totals[col] > SUM_MAX - addend)
                    column_totals[col] = SUM_MAX;
                else
                    column_totals[col] = column_totals[col] + addend;
            end
        end
        else
        begin
            if (use_typed)
                result.sum = typed_sum;
            else if (int'(col) < MAX_COLUMNS)
                result.sum = column_totals[col];
            else
                result.sum = '0;
            result.sat = (result.sum == SUM_MAX);
            pending_reads.push_back(result);
        end
    endfunction

    // present one command and hold it until the block takes it
    task automatic issue(
        input logic                     op,
        input logic [COL_W-1:0]         col,
        input logic signed [PART_W-1:0] re,
        input logic signed [PART_W-1:0] im,
        input bit                       use_typed,
        input logic [SUM_W-1:0]         typed_sum
    );
        start     <= 1'b1;
        operation <= op;
        column    <= col;
        real_part <= re;
        imag_part <= im;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        account_transaction(op, col, re, im, use_typed, typed_sum);
        // sender gap
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 25))
                @(posedge clk);
        end
    endtask

    // stop issuing, let reads return and any add finish
    task automatic settle();
        start <= 1'b0;
        while (pending_reads.size() > 0)
            @(posedge clk);
        // a magnitude add stays busy through its root and returns nothing
        repeat (24)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_weight(input logic value);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we        <= 1'b0;
        unit_weight_q  = value;
    endtask

    function automatic directed_row_t row(
        input logic                     weight,
        input logic                     op,
        input logic [COL_W-1:0]         col,
        input logic signed [PART_W-1:0] re,
        input logic signed [PART_W-1:0] im,
        input bit                       typed,
        input logic [SUM_W-1:0]         typed_sum
    );
        directed_row_t r;
        r.weight    = weight;
        r.op        = op;
        r.col       = col;
        r.re        = re;
        r.im        = im;
        r.typed     = typed;
        r.typed_sum = typed_sum;
        return r;
    endfunction

    // mostly full-range parts, sometimes the extremes
    function automatic logic signed [PART_W-1:0] random_part();
        logic signed [PART_W-1:0] value;
        if ($urandom_range(0, 99) < 20)
        begin
            case ($urandom_range(0, 4))
                0:       value = 16'sh8000;
                1:       value = 16'sh7FFF;
                2:       value = 16'sh0000;
                3:       value = 16'shFFFF;
                default: value = 16'sh0001;
            endcase
        end
        else
        begin
            value = PART_W'($urandom);
        end
        return value;
    endfunction

    // result checker: the receiver cannot stall, sample every strobe
    always @(posedge clk)
    begin
        column_read_t want;
        if (rst_n && done)
        begin
            if (pending_reads.size() == 0)
            begin
                report_mismatch($sformatf("result with none expected: sum %0d", column_sum));
            end
            else
            begin
                want = pending_reads.pop_front();
                if (column_sum !== want.sum)
                    report_mismatch($sformatf("column_sum got %0d expected %0d",
                                              column_sum, want.sum));
                if (saturated !== want.sat)
                    report_mismatch($sformatf("saturated got %0b expected %0b",
                                              saturated, want.sat));
            end
        end
    end

    // stimulus
    initial
    begin
        directed_row_t            rows [$];
        logic                     op;
        logic [COL_W-1:0]         col;
        int                       pick;

        rst_n     <= 1'b0;
        start     <= 1'b0;
        operation <= OP_ADD;
        column    <= '0;
        real_part <= '0;
        imag_part <= '0;
        cfg_we    <= 1'b0;
        cfg_data  <= 1'b0;
        error_count   = 0;
        unit_weight_q = 1'b0;
        idle_pct      = 0;
        foreach (column_totals[i])
            column_totals[i] = '0;

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        // store clearing pass
        @(posedge clk);
        while (busy)
            @(posedge clk);

        // directed table: weight, op, column, re, im, typed, typed sum
        rows.push_back(row(1'b0, OP_READ, 10'd0,    16'sh0000, 16'sh0000, 1, 40'd0));
        rows.push_back(row(1'b0, OP_READ, 10'd1023, 16'sh7FFF, 16'sh8000, 1, 40'd0));
        rows.push_back(row(1'b0, OP_ADD,  10'd5,    16'sh8000, 16'sh8000, 0, 40'd0));
        rows.push_back(row(1'b0, OP_READ, 10'd5,    16'sh0000, 16'sh0000, 1, 40'd46340));
        rows.push_back(row(1'b0, OP_ADD,  10'd5,    16'sh7FFF, 16'sh0000, 0, 40'd0));
        rows.push_back(row(1'b0, OP_ADD,  10'd5,    16'sh0000, 16'sh8000, 0, 40'd0));
        rows.push_back(row(1'b0, OP_READ, 10'd5,    16'sh0000, 16'sh0000, 0, 40'd0));
        rows.push_back(row(1'b0, OP_ADD,  10'd1023, 16'sh0000, 16'sh0000, 0, 40'd0));
        rows.push_back(row(1'b0, OP_READ, 10'd1023, 16'sh0001, 16'sh0000, 1, 40'd0));
        rows.push_back(row(1'b0, OP_ADD,  10'd0,    16'shFFFF, 16'shFFFF, 0, 40'd0));
        rows.push_back(row(1'b0, OP_ADD,  10'd0,    16'sh0003, 16'shFFFC, 0, 40'd0));
        rows.push_back(row(1'b0, OP_ADD,  10'd0,    16'sh7FFF, 16'sh7FFF, 0, 40'd0));
        rows.push_back(row(1'b0, OP_READ, 10'd0,    16'sh0000, 16'sh0000, 0, 40'd0));
        rows.push_back(row(1'b0, OP_READ, 10'd7,    16'sh5555, 16'shAAAA, 1, 40'd0));
        rows.push_back(row(1'b1, OP_ADD,  10'd9,    16'sh8000, 16'sh7FFF, 0, 40'd0));
        rows.push_back(row(1'b1, OP_ADD,  10'd9,    16'sh0000, 16'sh0000, 0, 40'd0));
        rows.push_back(row(1'b1, OP_READ, 10'd9,    16'sh0000, 16'sh0000, 1, 40'd32768));
        rows.push_back(row(1'b1, OP_ADD,  10'd5,    16'sh1234, 16'shEDCB, 0, 40'd0));
        rows.push_back(row(1'b1, OP_READ, 10'd5,    16'sh0000, 16'sh0000, 0, 40'd0));
        rows.push_back(row(1'b1, OP_ADD,  10'd512,  16'sh8000, 16'sh8000, 0, 40'd0));
        rows.push_back(row(1'b1, OP_READ, 10'd512,  16'sh0000, 16'sh0000, 1, 40'd16384));

        foreach (rows[i])
        begin
            if (i == 0 || rows[i].weight !== unit_weight_q)
                write_weight(rows[i].weight);
            issue(rows[i].op, rows[i].col, rows[i].re, rows[i].im,
                  rows[i].typed, rows[i].typed_sum);
        end

        // random traffic in six phases of sender idling and weight mode
        for (int seg = 0; seg < 6; seg++)
        begin
            write_weight(logic'((seg + seg / 4) % 2));
            idle_pct = (seg < 2) ? 19 : (seg < 4) ? 67 : 0;
            repeat (200)
            begin
                op   = ($urandom_range(0, 99) < 60) ? OP_ADD : OP_READ;
                pick = $urandom_range(0, 99);
                // a few hot columns so reads see long sums
                if (pick < 50)
                    col = COL_W'($urandom_range(0, 7));
                else if (pick < 65)
                    col = COL_W'($urandom_range(MAX_COLUMNS - 8, MAX_COLUMNS - 1));
                else
                    col = COL_W'($urandom_range(0, MAX_COLUMNS - 1));
                issue(op, col, random_part(), random_part(), 0, '0);
            end
        end

        settle();
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
